FILE: rtl/kpv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpv_pkg
// Types, register-file map and the micro-program of the position/velocity
// filter sequencer.
// ----------------------------------------------------------------------------
package kpv_pkg;

   localparam int ADDR_W   = 5;
   localparam int DEPTH    = 30;
   localparam int PC_W     = 6;
   localparam int PROG_LEN = 54;

   localparam logic [31:0] ONE_Q24 = 32'sd16777216;

   // register file map
   localparam logic [ADDR_W-1:0] R_PE  = 5'd0;
   localparam logic [ADDR_W-1:0] R_VE  = 5'd1;
   localparam logic [ADDR_W-1:0] R_CPP = 5'd2;
   localparam logic [ADDR_W-1:0] R_CPV = 5'd3;
   localparam logic [ADDR_W-1:0] R_CVP = 5'd4;
   localparam logic [ADDR_W-1:0] R_CVV = 5'd5;
   localparam logic [ADDR_W-1:0] R_DT  = 5'd6;
   localparam logic [ADDR_W-1:0] R_VP  = 5'd7;
   localparam logic [ADDR_W-1:0] R_VA  = 5'd8;
   localparam logic [ADDR_W-1:0] R_PM  = 5'd9;
   localparam logic [ADDR_W-1:0] R_AM  = 5'd10;
   localparam logic [ADDR_W-1:0] R_DT2 = 5'd11;
   localparam logic [ADDR_W-1:0] R_DT3 = 5'd12;
   localparam logic [ADDR_W-1:0] R_P   = 5'd13;
   localparam logic [ADDR_W-1:0] R_V   = 5'd14;
   localparam logic [ADDR_W-1:0] R_QA  = 5'd15;
   localparam logic [ADDR_W-1:0] R_QB  = 5'd16;
   localparam logic [ADDR_W-1:0] R_N0  = 5'd17;
   localparam logic [ADDR_W-1:0] R_TA  = 5'd18;
   localparam logic [ADDR_W-1:0] R_N1  = 5'd19;
   localparam logic [ADDR_W-1:0] R_N2  = 5'd20;
   localparam logic [ADDR_W-1:0] R_N3  = 5'd21;
   localparam logic [ADDR_W-1:0] R_S   = 5'd22;
   localparam logic [ADDR_W-1:0] R_G0  = 5'd23;
   localparam logic [ADDR_W-1:0] R_G1  = 5'd24;
   localparam logic [ADDR_W-1:0] R_R   = 5'd25;
   localparam logic [ADDR_W-1:0] R_HP  = 5'd26;
   localparam logic [ADDR_W-1:0] R_HV  = 5'd27;
   localparam logic [ADDR_W-1:0] R_TC  = 5'd28;

   localparam logic [1:0] CSR_STEP_TIME     = 2'd0;
   localparam logic [1:0] CSR_MEASURE_NOISE = 2'd1;
   localparam logic [1:0] CSR_PROCESS_NOISE = 2'd2;

   typedef enum logic [2:0] {
      OP_MUL,
      OP_MULH,
      OP_ADD,
      OP_SUB,
      OP_DIV
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] b;
      logic [ADDR_W-1:0] dst;
   } uop_type;

   typedef struct packed {
      op_type op;
      logic   mul_load;
   } alu_ctrl_type;

   function automatic uop_type uop_fetch(input logic [PC_W-1:0] pc);
      uop_type u;
      case (pc)
         6'd0:    u = '{OP_MUL,  R_DT,  R_DT,  R_DT2};
         6'd1:    u = '{OP_MUL,  R_DT2, R_DT,  R_DT3};
         6'd2:    u = '{OP_MUL,  R_VE,  R_DT,  R_P};
         6'd3:    u = '{OP_ADD,  R_PE,  R_P,   R_P};
         6'd4:    u = '{OP_MULH, R_AM,  R_DT2, R_V};
         6'd5:    u = '{OP_ADD,  R_P,   R_V,   R_P};
         6'd6:    u = '{OP_MUL,  R_AM,  R_DT,  R_V};
         6'd7:    u = '{OP_ADD,  R_VE,  R_V,   R_V};
         6'd8:    u = '{OP_MUL,  R_VA,  R_DT2, R_QA};
         6'd9:    u = '{OP_MUL,  R_VA,  R_DT3, R_QB};
         6'd10:   u = '{OP_ADD,  R_CPV, R_CVP, R_N0};
         6'd11:   u = '{OP_MUL,  R_N0,  R_DT,  R_N0};
         6'd12:   u = '{OP_ADD,  R_CPP, R_N0,  R_N0};
         6'd13:   u = '{OP_MUL,  R_CVV, R_DT2, R_TA};
         6'd14:   u = '{OP_ADD,  R_N0,  R_TA,  R_N0};
         6'd15:   u = '{OP_ADD,  R_N0,  R_QA,  R_N0};
         6'd16:   u = '{OP_MUL,  R_CVV, R_DT,  R_TA};
         6'd17:   u = '{OP_ADD,  R_CPV, R_TA,  R_N1};
         6'd18:   u = '{OP_ADD,  R_N1,  R_QB,  R_N1};
         6'd19:   u = '{OP_ADD,  R_CVP, R_TA,  R_N2};
         6'd20:   u = '{OP_ADD,  R_N2,  R_QB,  R_N2};
         6'd21:   u = '{OP_ADD,  R_CVV, R_QA,  R_N3};
         6'd22:   u = '{OP_ADD,  R_N1,  R_N2,  R_S};
         6'd23:   u = '{OP_MUL,  R_S,   R_DT,  R_S};
         6'd24:   u = '{OP_ADD,  R_N0,  R_S,   R_S};
         6'd25:   u = '{OP_MUL,  R_N3,  R_DT2, R_G0};
         6'd26:   u = '{OP_ADD,  R_S,   R_G0,  R_S};
         6'd27:   u = '{OP_MUL,  R_VP,  R_VP,  R_G0};
         6'd28:   u = '{OP_ADD,  R_S,   R_G0,  R_S};
         6'd29:   u = '{OP_MUL,  R_N1,  R_DT,  R_G0};
         6'd30:   u = '{OP_ADD,  R_N0,  R_G0,  R_G0};
         6'd31:   u = '{OP_DIV,  R_G0,  R_S,   R_G0};
         6'd32:   u = '{OP_MUL,  R_N3,  R_DT,  R_G1};
         6'd33:   u = '{OP_ADD,  R_N2,  R_G1,  R_G1};
         6'd34:   u = '{OP_DIV,  R_G1,  R_S,   R_G1};
         6'd35:   u = '{OP_SUB,  R_PM,  R_P,   R_R};
         6'd36:   u = '{OP_MUL,  R_V,   R_DT,  R_TC};
         6'd37:   u = '{OP_SUB,  R_R,   R_TC,  R_R};
         6'd38:   u = '{OP_MUL,  R_G0,  R_R,   R_TC};
         6'd39:   u = '{OP_ADD,  R_P,   R_TC,  R_PE};
         6'd40:   u = '{OP_MUL,  R_G1,  R_R,   R_TC};
         6'd41:   u = '{OP_ADD,  R_V,   R_TC,  R_VE};
         6'd42:   u = '{OP_MUL,  R_N2,  R_DT,  R_HP};
         6'd43:   u = '{OP_ADD,  R_N0,  R_HP,  R_HP};
         6'd44:   u = '{OP_MUL,  R_N3,  R_DT,  R_HV};
         6'd45:   u = '{OP_ADD,  R_N1,  R_HV,  R_HV};
         6'd46:   u = '{OP_MUL,  R_G0,  R_HP,  R_TC};
         6'd47:   u = '{OP_SUB,  R_N0,  R_TC,  R_CPP};
         6'd48:   u = '{OP_MUL,  R_G0,  R_HV,  R_TC};
         6'd49:   u = '{OP_SUB,  R_N1,  R_TC,  R_CPV};
         6'd50:   u = '{OP_MUL,  R_G1,  R_HP,  R_TC};
         6'd51:   u = '{OP_SUB,  R_N2,  R_TC,  R_CVP};
         6'd52:   u = '{OP_MUL,  R_G1,  R_HV,  R_TC};
         6'd53:   u = '{OP_SUB,  R_N3,  R_TC,  R_CVV};
         default: u = '{OP_ADD,  R_PE,  R_PE,  R_TC};
      endcase
      return u;
   endfunction

endpackage

FILE: rtl/kpv_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpv_regfile
// Working store of the filter: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module kpv_regfile (
   input  logic                      clock,
   input  logic                      we,
   input  logic [kpv_pkg::ADDR_W-1:0] waddr,
   input  logic [31:0]               wdata,
   input  logic [kpv_pkg::ADDR_W-1:0] raddr_a,
   input  logic [kpv_pkg::ADDR_W-1:0] raddr_b,
   output logic [31:0]               rdata_a,
   output logic [31:0]               rdata_b
);

   logic [31:0] mem [kpv_pkg::DEPTH];
   logic [31:0] rdata_a_ff;
   logic [31:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

FILE: rtl/kpv_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpv_alu
// Shared saturating add/subtract and registered 32x32 multiplier with
// round-half-away-from-zero scaling by 24 or 25 bits.
// ----------------------------------------------------------------------------
module kpv_alu (
   input  logic                  clock,
   input  kpv_pkg::alu_ctrl_type ctrl,
   input  logic signed [31:0]    opa,
   input  logic signed [31:0]    opb,
   output logic        [31:0]    sum_res,
   output logic        [31:0]    mul_res
);

   logic signed [63:0] prod_ff;
   logic               sh25_ff;
   logic signed [32:0] sum_wide;
   logic               prod_neg;
   logic        [63:0] prod_mag;
   logic        [63:0] prod_rnd;
   logic        [63:0] prod_shift;

   always_ff @(posedge clock) begin
      if (ctrl.mul_load) begin
         prod_ff <= opa * opb;
         sh25_ff <= (ctrl.op == kpv_pkg::OP_MULH);
      end
   end

   always_comb begin
      if (ctrl.op == kpv_pkg::OP_SUB) begin
         sum_wide = {opa[31], opa} - {opb[31], opb};
      end else begin
         sum_wide = {opa[31], opa} + {opb[31], opb};
      end
      if (sum_wide > 33'sd2147483647) begin
         sum_res = 32'h7fffffff;
      end else if (sum_wide < -33'sd2147483648) begin
         sum_res = 32'h80000000;
      end else begin
         sum_res = sum_wide[31:0];
      end
   end

   always_comb begin
      prod_neg = prod_ff[63];
      prod_mag = prod_neg ? 64'(-prod_ff) : 64'(prod_ff);
      if (sh25_ff) begin
         prod_rnd   = prod_mag + (64'd1 << 24);
         prod_shift = prod_rnd >> 25;
      end else begin
         prod_rnd   = prod_mag + (64'd1 << 23);
         prod_shift = prod_rnd >> 24;
      end
      if (prod_neg) begin
         if (prod_shift >= 64'd2147483648) begin
            mul_res = 32'h80000000;
         end else begin
            mul_res = 32'(-prod_shift[31:0]);
         end
      end else if (prod_shift > 64'd2147483647) begin
         mul_res = 32'h7fffffff;
      end else begin
         mul_res = prod_shift[31:0];
      end
   end

endmodule

FILE: rtl/kpv_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpv_divider
// Restoring divider for Q8.24 quotients, one quotient bit per cycle,
// truncated toward zero and saturated; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module kpv_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic              busy,
   output logic              done,
   output logic [31:0]       quo
);

   localparam int DVD_W = 56;
   localparam int CNT_W = 6;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_RUN,
      DV_FIN
   } dv_state_type;

   dv_state_type       state_ff;
   logic [DVD_W-1:0]   dvd_ff;
   logic [31:0]        rem_ff;
   logic [31:0]        md_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               neg_ff;
   logic               done_ff;
   logic [31:0]        quo_ff;
   logic [31:0]        num_mag;
   logic [31:0]        den_mag;
   logic [32:0]        trial;
   logic               fits;

   assign num_mag = num[31] ? 32'(-num) : num;
   assign den_mag = den[31] ? 32'(-den) : den;
   assign trial   = {rem_ff, dvd_ff[DVD_W-1]} - {1'b0, md_ff};
   assign fits    = !trial[32];

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         case (state_ff)
            DV_IDLE: begin
               if (start) begin
                  md_ff  <= den_mag;
                  rem_ff <= '0;
                  neg_ff <= num[31] ^ den[31];
                  cnt_ff <= CNT_W'(DVD_W - 1);
                  if (den == 32'sd0) begin
                     dvd_ff   <= '0;
                     state_ff <= DV_FIN;
                  end else begin
                     dvd_ff   <= {num_mag, 24'd0};
                     state_ff <= DV_RUN;
                  end
               end
            end
            DV_RUN: begin
               rem_ff <= fits ? trial[31:0] : {rem_ff[30:0], dvd_ff[DVD_W-1]};
               dvd_ff <= {dvd_ff[DVD_W-2:0], fits};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= DV_FIN;
               end
            end
            DV_FIN: begin
               if (neg_ff) begin
                  quo_ff <= (dvd_ff >= 56'd2147483648) ? 32'h80000000
                                                        : 32'(-dvd_ff[31:0]);
               end else begin
                  quo_ff <= (dvd_ff > 56'd2147483647) ? 32'h7fffffff : dvd_ff[31:0];
               end
               done_ff  <= 1'b1;
               state_ff <= DV_IDLE;
            end
            default: begin
               state_ff <= DV_IDLE;
            end
         endcase
      end
   end

   assign busy = (state_ff != DV_IDLE);
   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

FILE: rtl/kalman_position_velocity_axis.sv
`timescale 1ns / 1ps
// sequence: an accepted item is loaded into the working store, then the 54-step
//   micro-program runs, a multiply adding a write-back and a divide a wait
// input: req_tready is low while an item runs, and an item waiting in ST_DONE
//   for a stalled result holds off the next one
// reset: synchronous; a sweep then writes the initial state into the
//   working store, req_tready stays low meanwhile, csr writes are taken as ever
// ----------------------------------------------------------------------------
// kalman_position_velocity_axis
// One-axis position/velocity filter in Q8.24, sequenced over one shared
// arithmetic unit and an iterative divider.
// ----------------------------------------------------------------------------
module kalman_position_velocity_axis (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // measured_position[31:0], measured_accel[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // filtered_position[31:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [24:0] csr_data
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_LOAD,
      ST_READ,
      ST_EXEC,
      ST_MULWB,
      ST_DIVWAIT,
      ST_DONE
   } state_type;

   state_type                   state_ff;
   logic [2:0]                  cnt_ff;
   logic [kpv_pkg::PC_W-1:0]    pc_ff;
   logic [24:0]                 dt_ff;
   logic [24:0]                 vp_ff;
   logic [24:0]                 va_ff;
   logic [31:0]                 pm_ff;
   logic [31:0]                 am_ff;
   logic [31:0]                 pos_ff;
   logic                        rsp_valid_ff;
   logic [31:0]                 rsp_data_ff;

   kpv_pkg::uop_type            uop;
   kpv_pkg::alu_ctrl_type       alu_ctrl;
   logic                        we;
   logic [kpv_pkg::ADDR_W-1:0]  waddr;
   logic [31:0]                 wdata;
   logic [31:0]                 rdata_a;
   logic [31:0]                 rdata_b;
   logic [31:0]                 sum_res;
   logic [31:0]                 mul_res;
   logic                        div_start;
   logic                        div_busy;
   logic                        div_done;
   logic [31:0]                 div_quo;
   logic                        last_op;
   logic                        rsp_load;

   assign uop       = kpv_pkg::uop_fetch(pc_ff);
   assign last_op   = (pc_ff == kpv_pkg::PC_W'(kpv_pkg::PROG_LEN - 1));
   assign div_start = (state_ff == ST_EXEC) && (uop.op == kpv_pkg::OP_DIV);
   assign alu_ctrl  = '{op: uop.op, mul_load: (state_ff == ST_EXEC)};
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   kpv_regfile u_regfile (
      .clock   (clock),
      .we      (we),
      .waddr   (waddr),
      .wdata   (wdata),
      .raddr_a (uop.a),
      .raddr_b (uop.b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   kpv_alu u_alu (
      .clock   (clock),
      .ctrl    (alu_ctrl),
      .opa     (rdata_a),
      .opb     (rdata_b),
      .sum_res (sum_res),
      .mul_res (mul_res)
   );

   kpv_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (rdata_a),
      .den   (rdata_b),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      we    = 1'b0;
      waddr = uop.dst;
      wdata = sum_res;
      case (state_ff)
         ST_INIT: begin
            we    = 1'b1;
            waddr = {2'b00, cnt_ff};
            wdata = (({2'b00, cnt_ff} == kpv_pkg::R_CPP) ||
                     ({2'b00, cnt_ff} == kpv_pkg::R_CVV)) ? kpv_pkg::ONE_Q24 : 32'd0;
         end
         ST_LOAD: begin
            we    = 1'b1;
            waddr = kpv_pkg::R_DT + {2'b00, cnt_ff};
            case (cnt_ff)
               3'd0:    wdata = {7'd0, dt_ff};
               3'd1:    wdata = {7'd0, vp_ff};
               3'd2:    wdata = {7'd0, va_ff};
               3'd3:    wdata = pm_ff;
               default: wdata = am_ff;
            endcase
         end
         ST_EXEC: begin
            we = (uop.op == kpv_pkg::OP_ADD) || (uop.op == kpv_pkg::OP_SUB);
         end
         ST_MULWB: begin
            we    = 1'b1;
            wdata = mul_res;
         end
         ST_DIVWAIT: begin
            we    = div_done;
            wdata = div_quo;
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= 25'd167772;
         vp_ff <= 25'd88852;
         va_ff <= 25'd36502;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            kpv_pkg::CSR_STEP_TIME:     dt_ff <= csr_data;
            kpv_pkg::CSR_MEASURE_NOISE: vp_ff <= csr_data;
            kpv_pkg::CSR_PROCESS_NOISE: va_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we && (waddr == kpv_pkg::R_PE)) begin
         pos_ff <= wdata;
      end
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_data_ff  <= pos_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_INIT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if ({2'b00, cnt_ff} == kpv_pkg::R_CVV) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  pm_ff    <= req_tdata[31:0];
                  am_ff    <= req_tdata[63:32];
                  cnt_ff   <= '0;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 3'd4) begin
                  pc_ff    <= '0;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               if ((uop.op == kpv_pkg::OP_MUL) || (uop.op == kpv_pkg::OP_MULH)) begin
                  state_ff <= ST_MULWB;
               end else if (uop.op == kpv_pkg::OP_DIV) begin
                  state_ff <= ST_DIVWAIT;
               end else if (last_op) begin
                  state_ff <= ST_DONE;
               end else begin
                  pc_ff    <= pc_ff + 1'b1;
                  state_ff <= ST_READ;
               end
            end
            ST_MULWB: begin
               if (last_op) begin
                  state_ff <= ST_DONE;
               end else begin
                  pc_ff    <= pc_ff + 1'b1;
                  state_ff <= ST_READ;
               end
            end
            ST_DIVWAIT: begin
               if (div_done) begin
                  pc_ff    <= pc_ff + 1'b1;
                  state_ff <= ST_READ;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // divider is started only when free
   assert property (@(posedge clock) disable iff (reset) div_start |-> !div_busy)
      else $error("divider started while busy");

   // no item is taken while a divide is in flight
   assert property (@(posedge clock) disable iff (reset) req_tready |-> !div_busy)
      else $error("input ready during divide");

   // the state sweep after reset holds off input items
   assert property (@(posedge clock) reset |=> !req_tready)
      else $error("input ready right after reset");

   // the program counter stays inside the micro-program
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> (pc_ff < kpv_pkg::PC_W'(kpv_pkg::PROG_LEN)))
      else $error("program counter out of range");

endmodule

FILE: tb/kalman_position_velocity_axis_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_position_velocity_axis_test
// Drives position/acceleration items into the one-axis filter, predicts each
// filtered position with a bit-exact fixed-point model of the filter and
// compares every result; covers register extremes, idle and stall patterns.
// ----------------------------------------------------------------------------
module kalman_position_velocity_axis_test;

   localparam longint MAX32 = 64'sd2147483647;
   localparam longint MIN32 = -64'sd2147483648;
   localparam int LIMIT_CYCLES = 900000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = kpv_pkg::CSR_STEP_TIME;
   logic [24:0] csr_data = '0;

   kalman_position_velocity_axis dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // filter state of the predictor
   int          st_dt, st_vp, st_va;
   int          est_pos, est_vel, c_pp, c_pv, c_vp, c_vv;
   logic [31:0] expected_positions[$];
   int          mismatch_count = 0;
   int          result_count = 0;
   int          sent_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   bit          hold_off = 1'b0;

   function automatic int sat(longint x);
      if (x > MAX32) return int'(MAX32);
      if (x < MIN32) return int'(MIN32);
      return int'(x);
   endfunction

   function automatic int qadd(int a, int b);
      return sat(longint'(a) + longint'(b));
   endfunction

   function automatic int qsub(int a, int b);
      return sat(longint'(a) - longint'(b));
   endfunction

   function automatic int qmulsh(int a, int b, int sh);
      longint p;
      longint unsigned m;
      p = longint'(a) * longint'(b);
      m = (p < 0) ? longint'(-p) : longint'(p);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      if (p < 0) return sat(-longint'(m > 64'd2147483648 ? 64'd2147483648 : m));
      return sat(longint'(m > 64'd2147483647 ? 64'd2147483647 : m));
   endfunction

   function automatic int qmul(int a, int b);
      return qmulsh(a, b, 24);
   endfunction

   function automatic int qdiv(int num, int den);
      longint unsigned mn, md, q;
      if (den == 0) return 0;
      mn = (num < 0) ? longint'(-longint'(num)) : longint'(num);
      md = (den < 0) ? longint'(-longint'(den)) : longint'(den);
      q = (mn << 24) / md;
      if ((num < 0) != (den < 0)) return sat(-longint'(q > 64'd2147483648 ? 64'd2147483648 : q));
      return sat(longint'(q > 64'd2147483647 ? 64'd2147483647 : q));
   endfunction

   function automatic void reset_filter();
      st_dt = 167772; st_vp = 88852; st_va = 36502;
      est_pos = 0; est_vel = 0;
      c_pp = int'(kpv_pkg::ONE_Q24); c_pv = 0; c_vp = 0; c_vv = int'(kpv_pkg::ONE_Q24);
   endfunction

   function automatic logic [31:0] filter_step(int pm, int am);
      int dt2, dt3, p, v, qa, qb, n0, n1, n2, n3, s, g0, g1, r, hp, hv;
      dt2 = qmul(st_dt, st_dt);
      dt3 = qmul(dt2, st_dt);
      p = qadd(qadd(est_pos, qmul(est_vel, st_dt)), qmulsh(am, dt2, 25));
      v = qadd(est_vel, qmul(am, st_dt));
      qa = qmul(st_va, dt2);
      qb = qmul(st_va, dt3);
      n0 = qadd(qadd(qadd(c_pp, qmul(qadd(c_pv, c_vp), st_dt)), qmul(c_vv, dt2)), qa);
      n1 = qadd(qadd(c_pv, qmul(c_vv, st_dt)), qb);
      n2 = qadd(qadd(c_vp, qmul(c_vv, st_dt)), qb);
      n3 = qadd(c_vv, qa);
      s = qadd(qadd(qadd(n0, qmul(qadd(n1, n2), st_dt)), qmul(n3, dt2)),
               qmul(st_vp, st_vp));
      g0 = qdiv(qadd(n0, qmul(n1, st_dt)), s);
      g1 = qdiv(qadd(n2, qmul(n3, st_dt)), s);
      r = qsub(qsub(pm, p), qmul(v, st_dt));
      est_pos = qadd(p, qmul(g0, r));
      est_vel = qadd(v, qmul(g1, r));
      hp = qadd(n0, qmul(n2, st_dt));
      hv = qadd(n1, qmul(n3, st_dt));
      c_pp = qsub(n0, qmul(g0, hp));
      c_pv = qsub(n1, qmul(g0, hv));
      c_vp = qsub(n2, qmul(g1, hp));
      c_vv = qsub(n3, qmul(g1, hv));
      return est_pos;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result checker and receiver stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            result_count <= result_count + 1;
            if (expected_positions.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10) $display("unexpected item %h", rsp_tdata);
            end else begin
               logic [31:0] want;
               want = expected_positions.pop_front();
               if (want !== rsp_tdata) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("filtered_position mismatch: expected %h actual %h",
                              want, rsp_tdata);
               end
            end
         end
         rsp_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_item(int pm, int am);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {am, pm};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_positions.push_back(filter_step(pm, am));
      sent_count++;
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (expected_positions.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [24:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == kpv_pkg::CSR_STEP_TIME) st_dt = int'(val);
      else if (idx == kpv_pkg::CSR_MEASURE_NOISE) st_vp = int'(val);
      else st_va = int'(val);
      @(posedge clock);
   endtask

   function automatic int rand_pos();
      case ($urandom_range(3))
         0: return int'($urandom());
         1: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
         default: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      endcase
   endfunction

   task automatic test_directed();
      send_item(0, 0);
      send_item(int'(MAX32), 0);
      send_item(int'(MIN32), 0);
      send_item(0, int'(MAX32));
      send_item(0, int'(MIN32));
      send_item(int'(MAX32), int'(MAX32));
      send_item(int'(MIN32), int'(MIN32));
      send_item(-1, -1);
      send_item(int'(kpv_pkg::ONE_Q24), int'(kpv_pkg::ONE_Q24));
      send_item(32'h5555_5555, 32'hAAAA_AAAA);
      send_item(32'hAAAA_AAAA, 32'h5555_5555);
      drain();
   endtask

   task automatic test_register_extremes();
      // zero step time and zero noise, then full-scale registers, then the smallest step time with unit noise
      write_csr(kpv_pkg::CSR_STEP_TIME, 25'd0);
      write_csr(kpv_pkg::CSR_MEASURE_NOISE, 25'd0);
      write_csr(kpv_pkg::CSR_PROCESS_NOISE, 25'd0);
      repeat (4) send_item(rand_pos(), rand_pos());
      drain();
      write_csr(kpv_pkg::CSR_STEP_TIME, 25'h1FF_FFFF);
      write_csr(kpv_pkg::CSR_MEASURE_NOISE, 25'h1FF_FFFF);
      write_csr(kpv_pkg::CSR_PROCESS_NOISE, 25'h1FF_FFFF);
      repeat (4) send_item(rand_pos(), rand_pos());
      drain();
      write_csr(kpv_pkg::CSR_STEP_TIME, 25'd1);
      write_csr(kpv_pkg::CSR_MEASURE_NOISE, 25'd1 << 24);
      write_csr(kpv_pkg::CSR_PROCESS_NOISE, 25'd1 << 24);
      repeat (4) send_item(rand_pos(), rand_pos());
      drain();
   endtask

   task automatic test_random_phase(int n, int idle, int stall);
      send_idle_pct = idle;
      stall_pct = stall;
      write_csr(kpv_pkg::CSR_STEP_TIME, 25'($urandom_range(1, 1 << 23)));
      write_csr(kpv_pkg::CSR_MEASURE_NOISE, 25'($urandom_range(0, 1 << 24)));
      write_csr(kpv_pkg::CSR_PROCESS_NOISE, 25'($urandom_range(0, 1 << 24)));
      repeat (n) send_item(rand_pos(), rand_pos());
      drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      fork
         begin
            int held;
            hold_off = 1'b1;
            for (held = 0; held < 1500; held++) @(posedge clock);
            hold_off = 1'b0;
         end
         repeat (6) send_item(rand_pos(), rand_pos());
      join
      drain();
   endtask

   initial begin
      reset_filter();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_register_extremes();
      test_backpressure();
      test_random_phase(130, 0, 0);
      test_random_phase(130, 58, 0);
      test_random_phase(130, 0, 58);
      test_random_phase(130, 22, 22);
      $display("covered %0d items, %0d results, register extremes and long receiver hold-off",
               sent_count, result_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
